### rtl/core/mes_pkg.sv
// mes_pkg: shared constants, types and helper functions of the mask etch stencil
// used by every module under rtl/core except mes_ram; depends on nothing else
package mes_pkg;

    // line store geometry
    localparam int MAX_COLS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int NUMCOL_W = 11;
    localparam int NCOL_W   = (COL_W + 1 > NUMCOL_W) ? COL_W + 1 : NUMCOL_W;

    // field widths
    localparam int ROW_W     = 16;
    localparam int OUT_COL_W = 10;
    localparam int H_W       = 32;
    localparam int DEPTH_W   = 31;
    localparam int MASK_W    = 8;
    localparam int AMT_W     = DEPTH_W + 2;
    localparam int UNIT_W    = 3;

    // stream and register port widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 64;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 4;

    // mask levels below this are open
    localparam logic [MASK_W-1:0] OPEN_LIMIT = MASK_W'(128);

    // etch modes
    localparam logic MODE_ISO   = 1'b0;
    localparam logic MODE_ANISO = 1'b1;

    // result queue
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_PW    = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CW    = OFIFO_PW + 1;

    // register map, word index
    typedef enum logic [1:0] {
        REG_ETCH_MODE  = 2'd0,
        REG_ETCH_DEPTH = 2'd1,
        REG_NUM_ROWS   = 2'd2,
        REG_NUM_COLS   = 2'd3
    } t_reg_idx;

    // position of an accepted word with its boundary flags
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last_row;
        logic             last_col;
        logic             r_ge1;
        logic             r_ge2;
        logic             r_ge3;
        logic             c_ge1;
        logic             c_ge2;
        logic             c_p1_lt;
        logic             c_p2_lt;
    } t_pos;

    // one line store entry
    typedef struct packed {
        logic [H_W-1:0] h;
        logic           op1;
        logic           op2;
    } t_line;

    // a result waiting for its subtraction
    typedef struct packed {
        logic             vld;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [H_W-1:0]   h;
        logic [AMT_W-1:0] amount;
        logic             last;
        logic             fend;
    } t_cand;

    // a finished result
    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic [H_W-1:0]       h;
        logic                 last;
        logic                 fend;
    } t_res;

    // up to two results pushed in one cycle, in order
    typedef struct packed {
        logic [1:0] vld;
        t_res       res0;
        t_res       res1;
    } t_push;

    // result queue status
    typedef struct packed {
        logic [OFIFO_CW-1:0] count;
        logic                empty;
    } t_ofifo_stat;

    // depth * units / 2, rounded down
    function automatic logic [AMT_W-1:0] etch_amount(input logic [DEPTH_W-1:0] depth,
                                                     input logic [UNIT_W-1:0] units);
        logic [DEPTH_W+2:0] d;
        logic [DEPTH_W+2:0] p;
        d = {3'b000, depth};
        case (units)
            3'd0:    p = '0;
            3'd1:    p = d;
            3'd2:    p = d << 1;
            3'd3:    p = d + (d << 1);
            3'd4:    p = d << 2;
            3'd5:    p = d + (d << 2);
            3'd6:    p = (d << 1) + (d << 2);
            default: p = (d << 3) - d;
        endcase
        return p[DEPTH_W+2:1];
    endfunction

    // height minus amount, clamped at the most negative value
    function automatic logic [H_W-1:0] sat_sub(input logic [H_W-1:0] h,
                                               input logic [AMT_W-1:0] amount);
        logic [H_W+2:0] diff;
        logic [H_W-1:0] res;
        diff = {{3{h[H_W-1]}}, h} - {2'b00, amount};
        if (diff[H_W+2] && !(&diff[H_W+2:H_W-1])) begin
            res = {1'b1, {(H_W-1){1'b0}}};
        end else begin
            res = diff[H_W-1:0];
        end
        return res;
    endfunction

endpackage

### rtl/core/mes_ram.sv
// mes_ram: generic single-write, single-read RAM with registered read data
// standalone, no package needed
module mes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/mes_pos.sv
// mes_pos: raster position counters with dimension clamping and wrap
// depends on mes_pkg
module mes_pos
    import mes_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic [ROW_W-1:0]    i_num_rows,
    input  logic [NUMCOL_W-1:0] i_num_cols,
    output t_pos                o_pos
);

    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;

    logic [NCOL_W-1:0] c_in;
    logic [NCOL_W-1:0] c_eff;
    logic [NCOL_W-1:0] c_ext;
    logic [ROW_W-1:0]  r_eff;
    logic [ROW_W:0]    row_t;
    logic              col_wrap;
    logic              row_wrap;
    t_pos              pos;

    // effective dimensions
    always_comb begin
        c_in = NCOL_W'(i_num_cols);
        if (c_in == '0) begin
            c_eff = NCOL_W'(1);
        end else if (c_in > NCOL_W'(MAX_COLS)) begin
            c_eff = NCOL_W'(MAX_COLS);
        end else begin
            c_eff = c_in;
        end
        r_eff = (i_num_rows == '0) ? ROW_W'(1) : i_num_rows;
    end

    // normalise the stored position against the current dimensions
    always_comb begin
        col_wrap = NCOL_W'(r_col) >= c_eff;
        row_t    = {1'b0, r_row} + (ROW_W + 1)'(col_wrap);
        row_wrap = row_t >= {1'b0, r_eff};

        pos.col  = col_wrap ? '0 : r_col;
        pos.row  = row_wrap ? '0 : row_t[ROW_W-1:0];
        c_ext    = NCOL_W'(pos.col);

        pos.last_row = pos.row == (r_eff - ROW_W'(1));
        pos.last_col = (c_ext + NCOL_W'(1)) == c_eff;
        pos.r_ge1    = pos.row >= ROW_W'(1);
        pos.r_ge2    = pos.row >= ROW_W'(2);
        pos.r_ge3    = pos.row >= ROW_W'(3);
        pos.c_ge1    = c_ext >= NCOL_W'(1);
        pos.c_ge2    = c_ext >= NCOL_W'(2);
        pos.c_p1_lt  = (c_ext + NCOL_W'(1)) < c_eff;
        pos.c_p2_lt  = (c_ext + NCOL_W'(2)) < c_eff;
    end

    // next position after an accepted word
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (pos.last_col) begin
                n_col = '0;
                n_row = pos.last_row ? '0 : pos.row + ROW_W'(1);
            end else begin
                n_col = pos.col + COL_W'(1);
                n_row = pos.row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_pos = pos;

endmodule

### rtl/core/mes_etch.sv
// mes_etch: result stage, subtracts the removal amount with saturation
// depends on mes_pkg
module mes_etch
    import mes_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cand  i_cand0,
    input  t_cand  i_cand1,
    output t_push  o_push,
    output logic   o_busy
);

    t_cand r_c0;
    t_cand r_c1;

    // stage register, only the valid bits are reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0.vld <= 1'b0;
            r_c1.vld <= 1'b0;
        end else begin
            r_c0 <= i_cand0;
            r_c1 <= i_cand1;
        end
    end

    // saturating subtract and result formatting
    always_comb begin
        o_push.vld       = {r_c1.vld, r_c0.vld};
        o_push.res0.row  = r_c0.row;
        o_push.res0.col  = OUT_COL_W'(r_c0.col);
        o_push.res0.h    = sat_sub(r_c0.h, r_c0.amount);
        o_push.res0.last = r_c0.last;
        o_push.res0.fend = r_c0.fend;
        o_push.res1.row  = r_c1.row;
        o_push.res1.col  = OUT_COL_W'(r_c1.col);
        o_push.res1.h    = sat_sub(r_c1.h, r_c1.amount);
        o_push.res1.last = r_c1.last;
        o_push.res1.fend = r_c1.fend;
    end

    assign o_busy = r_c0.vld | r_c1.vld;

endmodule

### rtl/core/mes_ofifo.sv
// mes_ofifo: result queue taking up to two words a cycle and giving one
// depends on mes_pkg
module mes_ofifo
    import mes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_push       i_push,
    input  logic        i_pop_ready,
    output logic        o_pop_valid,
    output t_res        o_head,
    output t_ofifo_stat o_stat
);

    t_res                r_mem [OFIFO_DEPTH];
    logic [OFIFO_PW-1:0] r_wp;
    logic [OFIFO_PW-1:0] r_rp;
    logic [OFIFO_CW-1:0] r_cnt;
    logic [OFIFO_PW-1:0] n_wp;
    logic [OFIFO_PW-1:0] n_rp;
    logic [OFIFO_CW-1:0] n_cnt;
    logic [1:0]          n_push;
    logic                pop;
    t_res                first;

    // push count and first word in order
    always_comb begin
        n_push = {1'b0, i_push.vld[0]} + {1'b0, i_push.vld[1]};
        first  = i_push.vld[0] ? i_push.res0 : i_push.res1;
        pop    = (r_cnt != '0) && i_pop_ready;
        n_wp   = r_wp + OFIFO_PW'(n_push);
        n_rp   = r_rp + OFIFO_PW'(pop);
        n_cnt  = r_cnt + OFIFO_CW'(n_push) - OFIFO_CW'(pop);
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_mem[r_wp] <= first;
        end
        if (n_push == 2'd2) begin
            r_mem[r_wp + OFIFO_PW'(1)] <= i_push.res1;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    assign o_pop_valid  = r_cnt != '0;
    assign o_head       = r_mem[r_rp];
    assign o_stat.count = r_cnt;
    assign o_stat.empty = r_cnt == '0;

endmodule

### rtl/core/mask_etch_stencil.sv
// Mask etch stencil: one cell word is taken per cycle while s_tready is high,
// in raster order; the etched result for a cell leaves one row later (the last
// row gives two results per word). A word's results pass the line store stage
// register and the result stage register before they enter the result queue.
// The sustained rate is one word a cycle, set by the one read and the one
// write-back each word makes in each line store RAM, with forwarding when a
// read meets the entry being written; during the last row the output side
// drains one result a cycle, so input runs at half rate there. s_tready drops
// when the eight-entry result queue cannot hold everything in flight.
// Configuration registers sit on the APB port: mode at 0x0, depth at 0x4,
// rows at 0x8, columns at 0xC. Line store contents are not cleared, so no clearing pass.
// Depends on mes_pkg, mes_ram, mes_pos, mes_etch and mes_ofifo.
module mask_etch_stencil
    import mes_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // height[31:0], mask_level[39:32]
    // result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // out_row[15:0], out_col[25:16],
                                           // new_height[57:26], zeros above
    output logic                 m_tlast,  // frame_end
    output logic                 m_tuser   // last_of_item
);

    // configuration registers
    logic                r_mode;
    logic [DEPTH_W-1:0]  r_depth;
    logic [ROW_W-1:0]    r_num_rows;
    logic [NUMCOL_W-1:0] r_num_cols;
    logic                cfg_we;
    t_reg_idx            cfg_idx;

    // accept stage
    logic                in_fire;
    t_pos                pos;
    logic [COL_W-1:0]    rb_addr;

    // line store stage
    logic                r_s1_vld;
    t_pos                r_s1_pos;
    logic [H_W-1:0]      r_s1_h;
    logic                r_s1_open;
    logic                r_left;
    logic                r_fa_hit;
    t_line               r_fa_word;
    logic                r_fb_hit;
    logic                r_fb;
    t_line               rd_a;
    logic                rd_b;
    t_line               word;
    t_line               wr_a;
    logic                right;
    logic                c_in;
    logic [UNIT_W-1:0]   units0;
    logic [UNIT_W-1:0]   units1;
    t_cand               cand0;
    t_cand               cand1;

    // result side
    t_push               push;
    logic                s2_busy;
    t_res                head;
    t_ofifo_stat         stat;
    logic [OFIFO_CW+1:0] need;

    // register writes
    assign cfg_we  = psel & penable & pwrite & pready;
    assign cfg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_ISO;
            r_depth    <= '0;
            r_num_rows <= ROW_W'(3);
            r_num_cols <= NUMCOL_W'(3);
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_ETCH_MODE:  r_mode     <= pwdata[0];
                REG_ETCH_DEPTH: r_depth    <= pwdata[DEPTH_W-1:0];
                REG_NUM_ROWS:   r_num_rows <= pwdata[ROW_W-1:0];
                REG_NUM_COLS:   r_num_cols <= pwdata[NUMCOL_W-1:0];
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (cfg_idx)
            REG_ETCH_MODE:  prdata = APB_DW'(r_mode);
            REG_ETCH_DEPTH: prdata = APB_DW'(r_depth);
            REG_NUM_ROWS:   prdata = APB_DW'(r_num_rows);
            REG_NUM_COLS:   prdata = APB_DW'(r_num_cols);
        endcase
    end

    // room for every result that can still arrive, including this word's two
    assign need     = (OFIFO_CW + 2)'(stat.count)
                    + (OFIFO_CW + 2)'({r_s1_vld, 1'b0})
                    + (OFIFO_CW + 2)'({s2_busy, 1'b0})
                    + (OFIFO_CW + 2)'(2);
    assign s_tready = need <= (OFIFO_CW + 2)'(OFIFO_DEPTH);
    assign in_fire  = s_tvalid & s_tready;

    mes_pos u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (in_fire),
        .i_num_rows (r_num_rows),
        .i_num_cols (r_num_cols),
        .o_pos      (pos)
    );

    // right neighbour is read one column ahead
    assign rb_addr = pos.col + COL_W'(1);

    // line store: previous height, previous open bit, open bit two rows up
    mes_ram #(
        .WIDTH ($bits(t_line)),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_pos.col),
        .i_wdata (wr_a),
        .i_raddr (pos.col),
        .o_rdata (rd_a)
    );

    // copy of the previous row's open bits for the look-ahead read
    mes_ram #(
        .WIDTH (1),
        .DEPTH (MAX_COLS)
    ) u_open_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_pos.col),
        .i_wdata (r_s1_open),
        .i_raddr (rb_addr),
        .o_rdata (rd_b)
    );

    // capture the accepted word and forwarding for same-entry write-backs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_fa_hit <= 1'b0;
            r_fb_hit <= 1'b0;
            r_left   <= 1'b0;
        end else begin
            r_s1_vld <= in_fire;
            r_fa_hit <= r_s1_vld && (r_s1_pos.col == pos.col);
            r_fb_hit <= r_s1_vld && (r_s1_pos.col == rb_addr);
            if (r_s1_vld) begin
                r_left <= word.op1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fa_word <= wr_a;
        r_fb      <= r_s1_open;
        if (in_fire) begin
            r_s1_pos  <= pos;
            r_s1_h    <= s_tdata[H_W-1:0];
            r_s1_open <= s_tdata[H_W+MASK_W-1:H_W] < OPEN_LIMIT;
        end
    end

    // read-modify-write of the line store entry
    always_comb begin
        word     = r_fa_hit ? r_fa_word : rd_a;
        right    = r_fb_hit ? r_fb : rd_b;
        wr_a.h   = r_s1_h;
        wr_a.op1 = r_s1_open;
        wr_a.op2 = word.op1;
    end

    // half-depth units for the cell above and for the last-row cell
    always_comb begin
        c_in = r_s1_pos.c_ge1 & r_s1_pos.c_p1_lt;
        if (r_mode == MODE_ANISO) begin
            units0 = {1'b0, word.op1, 1'b0};
            units1 = {1'b0, r_s1_open, 1'b0};
        end else begin
            units0 = {1'b0, word.op1 & r_s1_pos.r_ge2 & c_in, 1'b0}
                   + UNIT_W'(word.op2 & r_s1_pos.r_ge3 & c_in)
                   + UNIT_W'(r_s1_open & r_s1_pos.r_ge1 & ~r_s1_pos.last_row & c_in)
                   + UNIT_W'(r_left & r_s1_pos.r_ge2 & r_s1_pos.c_ge2)
                   + UNIT_W'(right & r_s1_pos.r_ge2 & r_s1_pos.c_p2_lt);
            units1 = UNIT_W'(word.op1 & r_s1_pos.r_ge2 & c_in);
        end
    end

    // results caused by this word
    always_comb begin
        cand0.vld    = r_s1_vld & r_s1_pos.r_ge1;
        cand0.row    = r_s1_pos.row - ROW_W'(1);
        cand0.col    = r_s1_pos.col;
        cand0.h      = word.h;
        cand0.amount = etch_amount(r_depth, units0);
        cand0.last   = ~r_s1_pos.last_row;
        cand0.fend   = 1'b0;

        cand1.vld    = r_s1_vld & r_s1_pos.last_row;
        cand1.row    = r_s1_pos.row;
        cand1.col    = r_s1_pos.col;
        cand1.h      = r_s1_h;
        cand1.amount = etch_amount(r_depth, units1);
        cand1.last   = 1'b1;
        cand1.fend   = r_s1_pos.last_col;
    end

    mes_etch u_etch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cand0 (cand0),
        .i_cand1 (cand1),
        .o_push  (push),
        .o_busy  (s2_busy)
    );

    mes_ofifo u_ofifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop_ready (m_tready),
        .o_pop_valid (m_tvalid),
        .o_head      (head),
        .o_stat      (stat)
    );

    // output word packing
    assign m_tdata = M_TDATA_W'({head.h, head.col, head.row});
    assign m_tlast = head.fend;
    assign m_tuser = head.last;

    // a new word is only taken with room for its two results
    a_room_on_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> stat.count <= OFIFO_CW'(OFIFO_DEPTH - 2))
        else $error("word accepted without room in the result queue");

    // results of a word reach the result stage in the next cycle
    a_stage_advance : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cand0.vld || cand1.vld) |=> s2_busy)
        else $error("results lost between line store stage and result stage");

    // forwarding only follows a write-back in the previous cycle
    a_fwd_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && (r_fa_hit || r_fb_hit)) |-> $past(r_s1_vld))
        else $error("line store forwarding without a write-back");

endmodule

### tb/mask_etch_stencil_tb.sv
// mask_etch_stencil_tb: self-checking bench for the mask etch stencil, with its own etch
// predictor, random stream idling and register changes between and within frames
// depends on mes_pkg and mask_etch_stencil
`timescale 1ns / 100ps

module mask_etch_stencil_tb
    import mes_pkg::*;
();

    localparam int     STALL_LIMIT   = 5000;
    localparam int     SETTLE_CYCLES = 16;
    localparam longint H_FLOOR       = -64'sh8000_0000;

    // tracks geometry, line stores and the etched cells still owed by the block
    class etched_cell_tracker;
        bit              mode;
        bit [30:0]       depth;
        bit [15:0]       rows;
        bit [10:0]       cols;
        bit [31:0]       line_h [MAX_COLS];
        bit              line_op1 [MAX_COLS];
        bit              line_op2 [MAX_COLS];
        bit              left_op;
        int              col_cnt;
        int              row_cnt;
        int              frames_done;
        int              mismatches;
        t_res            etched_due [$];

        function new();
            mode  = MODE_ISO;
            depth = '0;
            rows  = 16'd3;
            cols  = 11'd3;
            for (int i = 0; i < MAX_COLS; i++) begin
                line_h[i]   = '0;
                line_op1[i] = 1'b0;
                line_op2[i] = 1'b0;
            end
            left_op     = 1'b0;
            col_cnt     = 0;
            row_cnt     = 0;
            frames_done = 0;
            mismatches  = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] v);
            case (idx)
                REG_ETCH_MODE:  mode  = v[0];
                REG_ETCH_DEPTH: depth = v[30:0];
                REG_NUM_ROWS:   rows  = v[15:0];
                REG_NUM_COLS:   cols  = v[10:0];
                default: ;
            endcase
        endfunction

        function int eff_rows();
            return (rows < 1) ? 1 : int'(rows);
        endfunction

        function int eff_cols();
            if (cols < 1) return 1;
            if (cols > MAX_COLS) return MAX_COLS;
            return int'(cols);
        endfunction

        function bit interior(int r, int c);
            return r >= 1 && r + 1 < eff_rows() && c >= 1 && c + 1 < eff_cols();
        endfunction

        // height after etching, given the open flags of the cell and its neighbours
        function logic [31:0] etched_height(logic [31:0] h, int r, int c, bit own,
                                            bit up, bit down, bit lf, bit rt);
            longint removal;
            longint diff;
            int     halves;
            if (mode == MODE_ANISO) begin
                removal = own ? longint'(depth) : 0;
            end else begin
                halves = 0;
                if (own && interior(r, c))     halves += 2;
                if (up && interior(r - 1, c))   halves += 1;
                if (down && interior(r + 1, c)) halves += 1;
                if (lf && interior(r, c - 1))   halves += 1;
                if (rt && interior(r, c + 1))   halves += 1;
                removal = (longint'(depth) * halves) >>> 1;
            end
            diff = longint'($signed(h)) - removal;
            if (diff < H_FLOOR) diff = H_FLOOR;
            return diff[31:0];
        endfunction

        // accepted input word: queue the cells it releases, then update the line stores
        function void take_cell(logic [31:0] h, logic [7:0] m);
            int   nr;
            int   nc;
            int   r;
            int   c;
            bit   op;
            bit   last_row;
            bit   rt;
            bit   lf;
            t_res e;
            nr = eff_rows();
            nc = eff_cols();
            op = (m < OPEN_LIMIT);
            if (col_cnt >= nc) begin
                col_cnt = 0;
                row_cnt++;
            end
            if (row_cnt >= nr) row_cnt = 0;
            r = row_cnt;
            c = col_cnt;
            last_row = (r == nr - 1);
            // the cell one row up is now complete
            if (r >= 1) begin
                rt = (c + 1 < nc) ? line_op1[c + 1] : 1'b0;
                lf = (c >= 1) ? left_op : 1'b0;
                e.row  = ROW_W'(r - 1);
                e.col  = OUT_COL_W'(c);
                e.h    = etched_height(line_h[c], r - 1, c, line_op1[c], line_op2[c], op,
                                       lf, rt);
                e.last = !last_row;
                e.fend = 1'b0;
                etched_due.push_back(e);
            end
            // last row leaves straight away
            if (last_row) begin
                e.row  = ROW_W'(r);
                e.col  = OUT_COL_W'(c);
                e.h    = etched_height(h, r, c, op, (r >= 1) ? line_op1[c] : 1'b0,
                                       1'b0, 1'b0, 1'b0);
                e.last = 1'b1;
                e.fend = (c == nc - 1);
                etched_due.push_back(e);
            end
            left_op     = line_op1[c];
            line_op2[c] = line_op1[c];
            line_op1[c] = op;
            line_h[c]   = h;
            if (c == nc - 1) begin
                col_cnt = 0;
                if (last_row) begin
                    row_cnt = 0;
                    frames_done++;
                end else begin
                    row_cnt++;
                end
            end else begin
                col_cnt++;
            end
        endfunction

        function void match_result(logic [15:0] row, logic [9:0] col, logic [31:0] h,
                                   logic last, logic fend);
            t_res exp;
            if (etched_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: row %0d col %0d h %h last %b fend %b",
                             row, col, h, last, fend);
                return;
            end
            exp = etched_due.pop_front();
            if (row !== exp.row || col !== exp.col || h !== exp.h ||
                last !== exp.last || fend !== exp.fend) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: expected row %0d col %0d h %h last %b fend %b,",
                              " got row %0d col %0d h %h last %b fend %b"},
                             exp.row, exp.col, exp.h, exp.last, exp.fend,
                             row, col, h, last, fend);
            end
        endfunction

        function int pending();
            return etched_due.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n   = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [APB_AW-1:0]    paddr     = '0;
    logic [APB_DW-1:0]    pwdata    = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;  // height[31:0], mask_level[39:32]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // out_row[15:0], out_col[25:16], new_height[57:26]
    logic                 m_tlast;         // frame_end
    logic                 m_tuser;         // last_of_item

    etched_cell_tracker tracker = new();
    int gap_pct   = 6;
    int stall_pct = 69;
    int cells_fed = 0;
    int idle_run  = 0;

    // directed frame: extremes of height and mask around the open threshold
    logic [31:0] probe_h [9] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                 32'h8000_0000, 32'h0000_0001, 32'h8000_0005,
                                 32'h1234_5678, 32'h8000_0000, 32'hFFFF_FFFF};
    logic [7:0]  probe_m [9] = '{8'd255, 8'd0, 8'd127, 8'd128, 8'd0, 8'd0,
                                 8'd0, 8'd128, 8'd255};

    mask_etch_stencil dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result side: check accepted words, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            tracker.match_result(m_tdata[15:0], m_tdata[25:16], m_tdata[57:26],
                                 m_tuser, m_tlast);
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // watchdog on cycles without any word moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_run <= 0;
        end else begin
            idle_run <= idle_run + 1;
        end
        if (idle_run >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] pick_height();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h8000_0000 + $urandom_range(0, 32'h0002_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_mask();
        case ($urandom_range(0, 7))
            0:       return 8'd127;
            1:       return 8'd128;
            2:       return 8'd0;
            3:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // register write: setup then access cycle
    task automatic apb_write(input t_reg_idx idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.set_reg(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // all four registers, with junk in the unused upper bits
    task automatic configure(input logic m, input logic [30:0] d, input logic [15:0] r,
                             input logic [10:0] c);
        logic [31:0] junk;
        junk = $urandom;
        apb_write(REG_ETCH_MODE, {junk[31:1], m});
        apb_write(REG_ETCH_DEPTH, {junk[0], d});
        apb_write(REG_NUM_ROWS, {junk[31:16], r});
        apb_write(REG_NUM_COLS, {junk[31:11], c});
    endtask

    task automatic feed_cell(input logic [31:0] h, input logic [7:0] m);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {m, h};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        tracker.take_cell(h, m);
        cells_fed++;
    endtask

    task automatic feed_cells(input int n);
        repeat (n) feed_cell(pick_height(), pick_mask());
    endtask

    task automatic feed_frames(input int n);
        int target;
        target = tracker.frames_done + n;
        while (tracker.frames_done < target) feed_cell(pick_height(), pick_mask());
    endtask

    // drain all owed results, then let the pipeline empty of row-zero words
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // frames under random geometry until n more words have gone in
    task automatic run_random(input int n);
        int          stop_at;
        logic [15:0] r;
        logic [10:0] c;
        logic [30:0] d;
        stop_at = cells_fed + n;
        while (cells_fed < stop_at) begin
            case ($urandom_range(0, 3))
                0:       d = '0;
                1:       d = 31'h7FFF_FFFF;
                2:       d = 31'($urandom_range(1, 32'h0004_0000));
                default: d = 31'($urandom);
            endcase
            r = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2))
                                            : 16'($urandom_range(3, 6));
            case ($urandom_range(0, 9))
                0:       c = 11'($urandom_range(0, 2));
                1:       c = 11'($urandom_range(9, 40));
                default: c = 11'($urandom_range(3, 8));
            endcase
            settle();
            configure(1'($urandom_range(0, 1)), d, r, c);
            feed_frames($urandom_range(1, 3));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: full-depth frames in both modes, then a single-row frame
        configure(MODE_ISO, 31'h7FFF_FFFF, 16'd3, 11'd3);
        for (int i = 0; i < 9; i++) feed_cell(probe_h[i], probe_m[i]);
        settle();
        configure(MODE_ANISO, 31'h7FFF_FFFF, 16'd3, 11'd3);
        for (int i = 8; i >= 0; i--) feed_cell(probe_h[i], probe_m[i]);
        settle();
        configure(MODE_ISO, 31'd1, 16'd1, 11'd3);
        for (int i = 0; i < 3; i++) feed_cell(probe_h[i], probe_m[i]);

        // geometry shrunk mid-frame: column wrap, then row wrap
        settle();
        configure(MODE_ISO, 31'h0001_8000, 16'hFFFF, 11'd6);
        feed_cells(8);
        settle();
        configure(MODE_ISO, 31'h0001_8000, 16'hFFFF, 11'd2);
        feed_cells(4);
        settle();
        configure(MODE_ANISO, 31'h0001_8000, 16'd3, 11'd2);
        feed_frames(1);

        run_random(120);
        gap_pct   = 69;
        stall_pct = 6;
        run_random(120);

        // columns above the line store size clamp to full width, so part of a
        // first row stays silent; a narrower geometry then wraps into the last row
        settle();
        configure(MODE_ANISO, 31'($urandom), 16'd2, 11'h404);
        feed_cells(12);
        settle();
        configure(MODE_ANISO, 31'h0001_8000, 16'd2, 11'd6);
        feed_frames(1);

        gap_pct   = 0;
        stall_pct = 0;
        run_random(120);

        settle();
        if (tracker.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/mes_pkg.sv
rtl/core/mes_ram.sv
rtl/core/mes_pos.sv
rtl/core/mes_etch.sv
rtl/core/mes_ofifo.sv
rtl/core/mask_etch_stencil.sv
tb/mask_etch_stencil_tb.sv
